>>> hdl/rcad_pkg.sv
`default_nettype none
package rcad_pkg;

   // input item kinds
   typedef enum logic {
      KIND_TICK = 1'b0,
      KIND_LOAD = 1'b1
   } kind_type;

   // counter tops and rollover values
   localparam logic [5:0] SECOND_TOP = 6'd59;
   localparam logic [5:0] MINUTE_TOP = 6'd59;
   localparam logic [4:0] HOUR_TOP   = 5'd23;
   localparam logic [3:0] MONTH_TOP  = 4'd12;
   localparam logic [6:0] YEAR_TOP   = 7'd99;

   // reset values of the calendar
   localparam logic [5:0] SECOND_RESET = 6'd30;
   localparam logic [5:0] MINUTE_RESET = 6'd30;
   localparam logic [4:0] HOUR_RESET   = 5'd17;
   localparam logic [4:0] DAY_RESET    = 5'd14;
   localparam logic [3:0] MONTH_RESET  = 4'd12;
   localparam logic [6:0] YEAR_RESET   = 7'd16;

   // display line layout
   localparam int unsigned LineLen = 15;
   localparam logic [3:0] LAST_COL = 4'(LineLen - 1);

   localparam logic [5:0] CHAR_SLASH = 6'd47;
   localparam logic [5:0] CHAR_SPACE = 6'd32;
   localparam logic [5:0] CHAR_COLON = 6'd58;
   localparam logic [5:0] CHAR_ZERO  = 6'd48;

   // snapshot of the displayed fields, one per line
   typedef struct packed {
      logic [4:0] day;
      logic [3:0] month;
      logic [6:0] year;
      logic [4:0] hour;
      logic [5:0] minute;
   } snap_type;

   // write side of the line queue
   typedef struct packed {
      logic     push;
      snap_type data;
   } push_type;

   // read side of the line queue
   typedef struct packed {
      logic     full;
      logic     empty;
      snap_type head;
   } queue_status_type;

   // fixed month lengths, zero for codes that name no month
   function automatic logic [4:0] month_len(input logic [3:0] month);
      logic [4:0] len;
      case (month)
         4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
         4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
         4'd2:                                       len = 5'd28;
         default:                                    len = 5'd0;
      endcase
      return len;
   endfunction

   // one ascii digit of a two digit group, value taken modulo 100
   function automatic logic [5:0] digit_char(input logic [6:0] value,
                                             input logic       ones);
      logic [6:0]  m;
      logic [13:0] prod;
      logic [3:0]  tens;
      logic [6:0]  rem;
      m    = (value >= 7'd100) ? 7'(value - 7'd100) : value;
      // divide by ten through the reciprocal 103/1024, exact below 179
      prod = 14'(m) * 14'd103;
      tens = prod[13:10];
      rem  = 7'(m - 7'(tens) * 7'd10);
      return ones ? 6'(CHAR_ZERO + 6'(rem)) : 6'(CHAR_ZERO + 6'(tens));
   endfunction

   // character of the line at a given column
   function automatic logic [5:0] line_char(input snap_type snap,
                                            input logic [3:0] col);
      logic [5:0] c;
      case (col)
         4'd0, 4'd1:   c = digit_char(7'(snap.day), col == 4'd1);
         4'd3, 4'd4:   c = digit_char(7'(snap.month), col == 4'd4);
         4'd6, 4'd7:   c = digit_char(snap.year, col == 4'd7);
         4'd10, 4'd11: c = digit_char(7'(snap.hour), col == 4'd11);
         4'd13, 4'd14: c = digit_char(7'(snap.minute), col == 4'd14);
         4'd2, 4'd5:   c = CHAR_SLASH;
         4'd8, 4'd9:   c = CHAR_SPACE;
         4'd12:        c = CHAR_COLON;
         default:      c = CHAR_SPACE;
      endcase
      return c;
   endfunction

endpackage
`default_nettype wire

>>> hdl/rcad_front.sv
`default_nettype none
module rcad_front
   import rcad_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       accept,
   input  wire logic       kind,
   input  wire logic [4:0] load_day,
   input  wire logic [3:0] load_month,
   input  wire logic [6:0] load_year,
   input  wire logic [4:0] load_hour,
   input  wire logic [5:0] load_minute,
   input  wire logic [5:0] load_second,
   output push_type        push_out
);

   logic [5:0] second_ff, second_in;
   logic [5:0] minute_ff, minute_in;
   logic [4:0] hour_ff, hour_in;
   logic [4:0] day_ff, day_in;
   logic [3:0] month_ff, month_in;
   logic [6:0] year_ff, year_in;
   logic       line_in;
   logic [4:0] len;

   always_comb begin
      second_in = second_ff;
      minute_in = minute_ff;
      hour_in   = hour_ff;
      day_in    = day_ff;
      month_in  = month_ff;
      year_in   = year_ff;
      line_in   = 1'b0;
      len       = month_len(month_ff);
      if (accept) begin
         if (kind_type'(kind) == KIND_LOAD) begin
            day_in    = load_day;
            month_in  = load_month;
            year_in   = load_year;
            hour_in   = load_hour;
            minute_in = load_minute;
            second_in = load_second;
         end else if (second_ff < SECOND_TOP) begin
            second_in = 6'(second_ff + 6'd1);
         end else begin
            second_in = 6'd0;
            line_in   = 1'b1;
            if (minute_ff < MINUTE_TOP) begin
               minute_in = 6'(minute_ff + 6'd1);
            end else begin
               minute_in = 6'd0;
               if (hour_ff < HOUR_TOP) begin
                  hour_in = 5'(hour_ff + 5'd1);
               end else begin
                  hour_in = 5'd0;
                  // no month code: date stays as it is
                  if (len != 5'd0) begin
                     if (day_ff < len) begin
                        day_in = 5'(day_ff + 5'd1);
                     end else begin
                        day_in = 5'd1;
                        if (month_ff < MONTH_TOP) begin
                           month_in = 4'(month_ff + 4'd1);
                        end else begin
                           month_in = 4'd1;
                           year_in  = (year_ff < YEAR_TOP) ? 7'(year_ff + 7'd1) : 7'd0;
                        end
                     end
                  end
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         second_ff <= SECOND_RESET;
         minute_ff <= MINUTE_RESET;
         hour_ff   <= HOUR_RESET;
         day_ff    <= DAY_RESET;
         month_ff  <= MONTH_RESET;
         year_ff   <= YEAR_RESET;
      end else begin
         second_ff <= second_in;
         minute_ff <= minute_in;
         hour_ff   <= hour_in;
         day_ff    <= day_in;
         month_ff  <= month_in;
         year_ff   <= year_in;
      end
   end

   // line shows the updated calendar
   always_comb begin
      push_out.push        = line_in;
      push_out.data.day    = day_in;
      push_out.data.month  = month_in;
      push_out.data.year   = year_in;
      push_out.data.hour   = hour_in;
      push_out.data.minute = minute_in;
   end

endmodule
`default_nettype wire

>>> hdl/rcad_queue.sv
`default_nettype none
module rcad_queue
   import rcad_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire push_type   push_in,
   input  wire logic       pop,
   output queue_status_type status
);

   snap_type   mem_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_push;
   logic       do_pop;

   assign do_push = push_in.push && (count_ff != 2'd2);
   assign do_pop  = pop && (count_ff != 2'd0);

   always_comb begin
      wr_ptr_in = do_push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = 2'(count_ff + 2'd1);
      end else if (do_pop && !do_push) begin
         count_in = 2'(count_ff - 2'd1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_in.data;
      end
   end

   always_comb begin
      status.full  = (count_ff == 2'd2);
      status.empty = (count_ff == 2'd0);
      status.head  = mem_ff[rd_ptr_ff];
   end

endmodule
`default_nettype wire

>>> hdl/rcad_back.sv
`default_nettype none
module rcad_back
   import rcad_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire queue_status_type status,
   output logic             pop,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [5:0]       rsp_char_code,
   output logic [3:0]       rsp_position,
   output logic             rsp_last
);

   snap_type   snap_ff, snap_in;
   logic       busy_ff, busy_in;
   logic [3:0] col_ff, col_in;
   logic       valid_ff, valid_in;
   logic [5:0] char_ff, char_in;
   logic [3:0] pos_ff, pos_in;
   logic       last_ff, last_in;
   logic       advance;

   assign advance = !valid_ff || !rsp_stall;

   always_comb begin
      snap_in  = snap_ff;
      busy_in  = busy_ff;
      col_in   = col_ff;
      valid_in = valid_ff;
      char_in  = char_ff;
      pos_in   = pos_ff;
      last_in  = last_ff;
      pop      = 1'b0;
      if (advance) begin
         if (busy_ff) begin
            valid_in = 1'b1;
            char_in  = line_char(snap_ff, col_ff);
            pos_in   = col_ff;
            last_in  = (col_ff == LAST_COL);
            col_in   = 4'(col_ff + 4'd1);
            busy_in  = (col_ff != LAST_COL);
         end else if (!status.empty) begin
            // start next line straight from the queue head
            pop      = 1'b1;
            snap_in  = status.head;
            valid_in = 1'b1;
            char_in  = line_char(status.head, 4'd0);
            pos_in   = 4'd0;
            last_in  = 1'b0;
            col_in   = 4'd1;
            busy_in  = 1'b1;
         end else begin
            valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         valid_ff <= 1'b0;
         col_ff   <= 4'd0;
      end else begin
         busy_ff  <= busy_in;
         valid_ff <= valid_in;
         col_ff   <= col_in;
      end
   end

   always_ff @(posedge clock) begin
      snap_ff <= snap_in;
      char_ff <= char_in;
      pos_ff  <= pos_in;
      last_ff <= last_in;
   end

   assign rsp_valid     = valid_ff;
   assign rsp_char_code = char_ff;
   assign rsp_position  = pos_ff;
   assign rsp_last      = last_ff;

endmodule
`default_nettype wire

>>> hdl/rtc_calendar_with_ascii_display.sv
// channel   direction   handshake            payload
// req       in          req_valid/req_stall  kind, load day/month/year/hour/minute/second
// rsp       out         rsp_valid/rsp_stall  char_code, position, last
//
// a load or tick transfer is taken every cycle while the line queue has room
// a minute rollover queues one snapshot; the emitter sends 15 characters,
// one per cycle while rsp_stall is low, each from the character register
// the two-entry line queue raises req_stall only when full
// rsp_stall holds the character register; the calendar counts on until the queue fills
// synchronous reset loads 14/12/16 17:30:30 and empties queue and emitter
`default_nettype none
module rtc_calendar_with_ascii_display
   import rcad_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   // request channel
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic       req_kind,
   input  wire logic [4:0] req_load_day,
   input  wire logic [3:0] req_load_month,
   input  wire logic [6:0] req_load_year,
   input  wire logic [4:0] req_load_hour,
   input  wire logic [5:0] req_load_minute,
   input  wire logic [5:0] req_load_second,
   // response channel
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic [5:0]      rsp_char_code,
   output logic [3:0]      rsp_position,
   output logic            rsp_last
);

   push_type         push;
   queue_status_type status;
   logic             pop;
   logic             req_accept;

   // front may only run when a line it might produce has a slot
   assign req_stall  = status.full;
   assign req_accept = req_valid && !req_stall;

   // calendar counters and line snapshot
   rcad_front u_front (
      .clock       (clock),
      .reset       (reset),
      .accept      (req_accept),
      .kind        (req_kind),
      .load_day    (req_load_day),
      .load_month  (req_load_month),
      .load_year   (req_load_year),
      .load_hour   (req_load_hour),
      .load_minute (req_load_minute),
      .load_second (req_load_second),
      .push_out    (push)
   );

   // lines waiting for display
   rcad_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push_in (push),
      .pop     (pop),
      .status  (status)
   );

   // character emitter
   rcad_back u_back (
      .clock         (clock),
      .reset         (reset),
      .status        (status),
      .pop           (pop),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_char_code (rsp_char_code),
      .rsp_position  (rsp_position),
      .rsp_last      (rsp_last)
   );

endmodule
`default_nettype wire
